>>> sv/vbns_pkg.sv
`timescale 1ns / 1ps

package vbns_pkg;

  // Field widths
  localparam int unsigned SCAN_W      = 15;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned BURST_W     = 7;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned COLUMN_W    = 7;
  localparam int unsigned LINE_W      = 9;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned MAX_OUT     = 16;
  localparam int unsigned OUT_CNT_W   = 5;

  // Default geometry
  localparam int unsigned SAMPLES_PER_CYCLE_DEF = 14;
  localparam int unsigned CYCLES_PER_LINE_DEF   = 65;
  localparam int unsigned VISIBLE_ROWS_DEF      = 192;
  localparam int unsigned HIDDEN_COLUMNS_DEF    = 25;
  localparam int unsigned LONG_CYCLE_EXTRA_DEF  = 2;

  // Vertical sync lines [VSYNC_FIRST, VSYNC_END)
  localparam logic [LINE_W-1:0] VSYNC_FIRST = 9'd224;
  localparam logic [LINE_W-1:0] VSYNC_END   = 9'd240;
  localparam logic [LINE_W-1:0] LINE_MAX    = 9'd511;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_REVISION  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIT_LEVEL       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_TIP        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LEVEL     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HSYNC_BEGIN     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKPORCH_START = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_START     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_END       = 4'd7;

  // Register reset values
  localparam logic                      BOARD_REVISION_RST = 1'b1;
  localparam logic signed [LEVEL_W-1:0] LIT_LEVEL_RST      = 8'sd100;
  localparam logic signed [LEVEL_W-1:0] SYNC_TIP_RST       = -8'sd40;
  localparam logic [BURST_W-1:0]        BURST_LEVEL_RST    = 7'd20;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_index;
    logic [BYTE_W-1:0] video_byte;
    logic              displaying_text;
    logic              hires_mode;
    logic              text_mode;
  } in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] sample_level;
    logic                      last_sample;
  } out_t;

  typedef struct packed {
    logic                      board_revision;
    logic signed [LEVEL_W-1:0] lit_level;
    logic signed [LEVEL_W-1:0] sync_tip;
    logic [BURST_W-1:0]        burst_level;
    logic [POS_W-1:0]          hsync_begin;
    logic [POS_W-1:0]          backporch_start;
    logic [POS_W-1:0]          burst_start;
    logic [POS_W-1:0]          burst_end;
  } cfg_t;

  // Control from the sequencer to the pixel shifter
  typedef struct packed {
    logic load;       // load a new byte
    logic step;       // advance one sample
    logic txt;        // text path
    logic hir;        // hi-res path
    logic half;       // odd sample: half-rate paths shift
    logic lores_odd;  // lo-res: take nibble bit 2 instead of bit 0
    logic lores_hi;   // lo-res: take the upper nibble
  } sh_ctrl_t;

endpackage

>>> sv/vbns_cfg_regs.sv
`timescale 1ns / 1ps

module vbns_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [vbns_pkg::CFG_IDX_W-1:0]      wr_index_i,
  input  logic [vbns_pkg::CFG_DATA_W-1:0]     wr_data_i,
  output vbns_pkg::cfg_t                      cfg_o
);

  vbns_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        vbns_pkg::REG_BOARD_REVISION:  cfg_d.board_revision  = wr_data_i[0];
        vbns_pkg::REG_LIT_LEVEL:       cfg_d.lit_level       = $signed(wr_data_i[7:0]);
        vbns_pkg::REG_SYNC_TIP:        cfg_d.sync_tip        = $signed(wr_data_i[7:0]);
        vbns_pkg::REG_BURST_LEVEL:     cfg_d.burst_level     = wr_data_i[6:0];
        vbns_pkg::REG_HSYNC_BEGIN:     cfg_d.hsync_begin     = wr_data_i;
        vbns_pkg::REG_BACKPORCH_START: cfg_d.backporch_start = wr_data_i;
        vbns_pkg::REG_BURST_START:     cfg_d.burst_start     = wr_data_i;
        vbns_pkg::REG_BURST_END:       cfg_d.burst_end       = wr_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.board_revision  <= vbns_pkg::BOARD_REVISION_RST;
      cfg_q.lit_level       <= vbns_pkg::LIT_LEVEL_RST;
      cfg_q.sync_tip        <= vbns_pkg::SYNC_TIP_RST;
      cfg_q.burst_level     <= vbns_pkg::BURST_LEVEL_RST;
      cfg_q.hsync_begin     <= '0;
      cfg_q.backporch_start <= '0;
      cfg_q.burst_start     <= '0;
      cfg_q.burst_end       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/vbns_shifter.sv
`timescale 1ns / 1ps

module vbns_shifter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vbns_pkg::sh_ctrl_t            ctrl_i,
  input  logic [vbns_pkg::BYTE_W-1:0]   video_byte_i,
  output logic                          bit_o,
  output logic                          gs_lsb_o,
  output logic                          high_bit_o
);

  logic [vbns_pkg::BYTE_W-1:0] gs_q, gs_d;
  logic [vbns_pkg::BYTE_W-1:0] ts_q, ts_d;
  logic                        high_q, high_d;
  logic [3:0]                  nib;

  // Lo-res: pick one nibble, then bit 0 or bit 2 of it
  assign nib = ctrl_i.lores_hi ? gs_q[7:4] : gs_q[3:0];

  always_comb begin
    if (ctrl_i.txt) begin
      bit_o = ts_q[0];
    end else if (ctrl_i.hir) begin
      bit_o = gs_q[0];
    end else begin
      bit_o = ctrl_i.lores_odd ? nib[2] : nib[0];
    end
  end

  always_comb begin
    gs_d   = gs_q;
    ts_d   = ts_q;
    high_d = high_q;
    if (ctrl_i.load) begin
      if (ctrl_i.txt) begin
        ts_d = video_byte_i;
      end else begin
        gs_d   = video_byte_i;
        high_d = video_byte_i[7];
      end
    end else if (ctrl_i.step) begin
      if (ctrl_i.txt) begin
        if (ctrl_i.half) begin
          ts_d = {1'b0, ts_q[7:1]};
        end
      end else if (ctrl_i.hir) begin
        // shift right, bit 4 wraps into bit 7
        if (ctrl_i.half) begin
          gs_d = {gs_q[4], gs_q[7:1]};
        end
      end else begin
        // rotate each nibble right by one
        gs_d = {gs_q[4], gs_q[7:5], gs_q[0], gs_q[3:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q   <= '0;
      ts_q   <= '0;
      high_q <= 1'b0;
    end else begin
      gs_q   <= gs_d;
      ts_q   <= ts_d;
      high_q <= high_d;
    end
  end

  assign gs_lsb_o   = gs_q[0];
  assign high_bit_o = high_q;

endmodule

>>> sv/vbns_level.sv
`timescale 1ns / 1ps

module vbns_level #(
  parameter int unsigned HC_W = 10
) (
  input  vbns_pkg::cfg_t                         cfg_i,
  input  logic [HC_W-1:0]                        hc_i,
  input  logic                                   text_mode_i,
  input  logic                                   line_vis_i,
  input  logic [vbns_pkg::LINE_W-1:0]            line_count_i,
  output logic signed [vbns_pkg::LEVEL_W-1:0]    level_o
);

  localparam int unsigned CmpW = (HC_W > vbns_pkg::POS_W) ? HC_W : vbns_pkg::POS_W;

  logic [CmpW-1:0]                   hc_x;
  logic                              in_sync, in_burst, in_vsync;
  logic [1:0]                        phase;
  logic signed [vbns_pkg::LEVEL_W-1:0] sync_lvl, burst_lvl, hblank_lvl, vblank_lvl;

  assign hc_x     = CmpW'(hc_i);
  assign in_sync  = (CmpW'(cfg_i.hsync_begin) <= hc_x) &&
                    (hc_x < CmpW'(cfg_i.backporch_start));
  assign in_burst = (CmpW'(cfg_i.burst_start) <= hc_x) && (hc_x < CmpW'(cfg_i.burst_end));
  assign in_vsync = (line_count_i >= vbns_pkg::VSYNC_FIRST) &&
                    (line_count_i < vbns_pkg::VSYNC_END);
  assign phase    = hc_i[1:0] - cfg_i.burst_start[1:0];
  assign sync_lvl = in_sync ? cfg_i.sync_tip : '0;

  // Burst runs 0, -burst, 0, +burst from its start
  always_comb begin
    case (phase)
      2'd1:    burst_lvl = $signed(8'd0 - {1'b0, cfg_i.burst_level});
      2'd3:    burst_lvl = $signed({1'b0, cfg_i.burst_level});
      default: burst_lvl = '0;
    endcase
  end

  always_comb begin
    if (in_burst) begin
      hblank_lvl = (text_mode_i && cfg_i.board_revision) ? '0 : burst_lvl;
    end else begin
      hblank_lvl = sync_lvl;
    end
    vblank_lvl = in_vsync ? cfg_i.sync_tip : sync_lvl;
    level_o    = line_vis_i ? hblank_lvl : vblank_lvl;
  end

endmodule

>>> sv/video_byte_to_ntsc_samples_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// -------  ---  -----------------------  ------------------------------------
// in       in   in_valid_i/in_stall_o    vbns_pkg::in_t  (one video byte)
// out      out  out_valid_o/out_stall_i  vbns_pkg::out_t (one sample)
// cfg      in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte yields SAMPLES_PER_CYCLE samples, plus LONG_CYCLE_EXTRA on the last column of a line:
// the idle state takes the transfer, a setup state (ST_PREP) computes the multiplier terms,
// then one sample per clock comes out of the pixel shifter while the output does not stall.
// Reset is asynchronous; counters and shifters clear and the registers load their defaults.
// A stall on the output holds the sequencer; in_stall_o stays high from the accepted
// transfer until the last sample has been issued.

module video_byte_to_ntsc_samples_core #(
  parameter int unsigned SAMPLES_PER_CYCLE = vbns_pkg::SAMPLES_PER_CYCLE_DEF,
  parameter int unsigned CYCLES_PER_LINE   = vbns_pkg::CYCLES_PER_LINE_DEF,
  parameter int unsigned VISIBLE_ROWS      = vbns_pkg::VISIBLE_ROWS_DEF,
  parameter int unsigned HIDDEN_COLUMNS    = vbns_pkg::HIDDEN_COLUMNS_DEF,
  parameter int unsigned LONG_CYCLE_EXTRA  = vbns_pkg::LONG_CYCLE_EXTRA_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vbns_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vbns_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vbns_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vbns_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Sample counter covers the long cycle
  localparam int unsigned MaxCycles = SAMPLES_PER_CYCLE + LONG_CYCLE_EXTRA;
  localparam int unsigned CW        = $clog2(MaxCycles + 1);
  // Line sample index, including the increments on the last column
  localparam int unsigned HcMax     = (CYCLES_PER_LINE - 1) * SAMPLES_PER_CYCLE + MaxCycles;
  localparam int unsigned HcW       = $clog2(HcMax + 1);
  // scan_index / CYCLES_PER_LINE as a multiply by a rounded-up reciprocal;
  // the shift leaves enough guard bits that no correction is needed
  localparam int unsigned RecipShift = vbns_pkg::SCAN_W + $clog2(CYCLES_PER_LINE);
  localparam longint unsigned RecipM =
      ((64'd1 << RecipShift) + CYCLES_PER_LINE - 1) / CYCLES_PER_LINE;
  localparam int unsigned RecipW    = $clog2(RecipM + 1);
  localparam int unsigned ProdW     = vbns_pkg::SCAN_W + RecipW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN
  } state_e;

  state_e                                state_q;
  vbns_pkg::in_t                         item_q;
  logic [vbns_pkg::COLUMN_W-1:0]         column_q;
  logic [vbns_pkg::LINE_W-1:0]           line_q;
  logic                                  last_hires_q;
  logic [CW-1:0]                         c_q;
  logic [CW-1:0]                         cycles_last_q;
  logic [CW-1:0]                         first_blank_q;
  logic [vbns_pkg::OUT_CNT_W-1:0]        n_q;
  logic [3:0]                            count_last_q;
  logic                                  ins_q;
  logic                                  show_last_q;
  logic                                  line_vis_q;
  logic                                  h_vis_q;
  logic                                  lores_odd_q;
  logic                                  lores_hi_q;
  logic [HcW-1:0]                        hc_q;
  logic                                  out_valid_q;
  vbns_pkg::out_t                        out_q;

  vbns_pkg::cfg_t                        cfg;
  vbns_pkg::sh_ctrl_t                    sh_ctrl;
  logic                                  sh_bit, sh_gs_lsb, sh_high_bit;
  logic signed [vbns_pkg::LEVEL_W-1:0]   blank_lvl, pix_lvl, sample_lvl;

  logic                                  accept, out_free, emit_ok, go, last_flag;
  logic                                  is_long, shift;
  logic [CW-1:0]                         total;
  logic [ProdW-1:0]                      recip_prod;

  // ---------------------------------------------------------------------------
  // Registers and datapath units
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  vbns_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  // Samples past the sixteenth are dropped but still advance the state
  assign emit_ok  = !n_q[vbns_pkg::OUT_CNT_W-1];
  assign go       = (state_q == ST_RUN) && (!emit_ok || out_free);

  always_comb begin
    sh_ctrl.load      = accept;
    sh_ctrl.step      = go && !ins_q;
    sh_ctrl.txt       = accept ? in_data_i.displaying_text : item_q.displaying_text;
    sh_ctrl.hir       = item_q.hires_mode;
    sh_ctrl.half      = c_q[0];
    sh_ctrl.lores_odd = lores_odd_q;
    sh_ctrl.lores_hi  = lores_hi_q;
  end

  vbns_shifter u_shifter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sh_ctrl),
    .video_byte_i (in_data_i.video_byte),
    .bit_o        (sh_bit),
    .gs_lsb_o     (sh_gs_lsb),
    .high_bit_o   (sh_high_bit)
  );

  vbns_level #(
    .HC_W (HcW)
  ) u_level (
    .cfg_i        (cfg),
    .hc_i         (hc_q),
    .text_mode_i  (item_q.text_mode),
    .line_vis_i   (line_vis_q),
    .line_count_i (line_q),
    .level_o      (blank_lvl)
  );

  // ---------------------------------------------------------------------------
  // Setup terms, used in the prep clock
  // ---------------------------------------------------------------------------
  assign is_long    = (column_q == vbns_pkg::COLUMN_W'(CYCLES_PER_LINE - 1));
  assign total      = is_long ? CW'(MaxCycles) : CW'(SAMPLES_PER_CYCLE);
  // Half-pixel delay: hi-res graphics byte with bit 7 set, in the visible area, on board revision 1
  assign shift      = !item_q.displaying_text && item_q.hires_mode && sh_high_bit &&
                      (line_q < vbns_pkg::LINE_W'(VISIBLE_ROWS)) &&
                      (column_q >= vbns_pkg::COLUMN_W'(HIDDEN_COLUMNS)) &&
                      cfg.board_revision;
  assign recip_prod = ProdW'(item_q.scan_index) * ProdW'(RecipW'(RecipM));

  // ---------------------------------------------------------------------------
  // Sample selection
  // ---------------------------------------------------------------------------
  always_comb begin
    pix_lvl = (sh_bit && (c_q < first_blank_q)) ? cfg.lit_level : '0;
    if (ins_q) begin
      // inserted sample repeats the last hi-res bit of the previous byte
      sample_lvl = show_last_q ? cfg.lit_level : '0;
    end else if (line_vis_q && h_vis_q) begin
      sample_lvl = pix_lvl;
    end else begin
      sample_lvl = blank_lvl;
    end
  end

  assign last_flag = (n_q[3:0] == count_last_q);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      item_q        <= '0;
      column_q      <= '0;
      line_q        <= '0;
      last_hires_q  <= 1'b0;
      c_q           <= '0;
      cycles_last_q <= '0;
      first_blank_q <= '0;
      n_q           <= '0;
      count_last_q  <= '0;
      ins_q         <= 1'b0;
      show_last_q   <= 1'b0;
      line_vis_q    <= 1'b0;
      h_vis_q       <= 1'b0;
      lores_odd_q   <= 1'b0;
      lores_hi_q    <= 1'b0;
      hc_q          <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // Release the output register once taken; a new sample below overrides
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_q <= in_data_i;
            // scan index zero restarts the line count
            if (in_data_i.scan_index == '0) begin
              line_q <= '0;
            end
            state_q <= ST_PREP;
          end
        end

        ST_PREP: begin
          cycles_last_q <= total - CW'(shift) - CW'(1);
          first_blank_q <= CW'(SAMPLES_PER_CYCLE) - CW'(shift);
          count_last_q  <= (total > CW'(vbns_pkg::MAX_OUT)) ? 4'd15 : 4'(total - CW'(1));
          ins_q         <= shift;
          show_last_q   <= shift && last_hires_q;
          line_vis_q    <= (line_q < vbns_pkg::LINE_W'(VISIBLE_ROWS));
          h_vis_q       <= (column_q >= vbns_pkg::COLUMN_W'(HIDDEN_COLUMNS));
          lores_odd_q   <= (item_q.scan_index[0] == line_q[0]);
          lores_hi_q    <= recip_prod[RecipShift + 2];
          hc_q          <= HcW'(column_q * SAMPLES_PER_CYCLE);
          c_q           <= '0;
          n_q           <= '0;
          state_q       <= ST_RUN;
        end

        ST_RUN: begin
          if (go) begin
            if (emit_ok) begin
              out_valid_q       <= 1'b1;
              out_q.sample_level <= sample_lvl;
              out_q.last_sample <= last_flag;
              n_q               <= n_q + 1'b1;
            end
            if (ins_q) begin
              ins_q <= 1'b0;
            end else begin
              hc_q <= hc_q + 1'b1;
              c_q  <= c_q + 1'b1;
              if (c_q == cycles_last_q) begin
                last_hires_q <= sh_gs_lsb;
                // advance column, wrap into the next line
                if (column_q >= vbns_pkg::COLUMN_W'(CYCLES_PER_LINE - 1)) begin
                  column_q <= '0;
                  if (line_q != vbns_pkg::LINE_MAX) begin
                    line_q <= line_q + 1'b1;
                  end
                end else begin
                  column_q <= column_q + 1'b1;
                end
                state_q <= ST_IDLE;
              end
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SPC           = vbns_pkg::SAMPLES_PER_CYCLE_DEF;
  localparam int unsigned CPL           = vbns_pkg::CYCLES_PER_LINE_DEF;
  localparam int unsigned VIS_ROWS      = vbns_pkg::VISIBLE_ROWS_DEF;
  localparam int unsigned HIDDEN_COLS   = vbns_pkg::HIDDEN_COLUMNS_DEF;
  localparam int unsigned LONG_EXTRA    = vbns_pkg::LONG_CYCLE_EXTRA_DEF;
  localparam int unsigned SCAN_LAST     = 17029;
  // Index past the register list; the block must take the transfer and drop it
  localparam logic [vbns_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  vbns_pkg::in_t                   in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  vbns_pkg::out_t                  out_data_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [vbns_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [vbns_pkg::CFG_DATA_W-1:0] cfg_data_i;

  video_byte_to_ntsc_samples_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Handshake qualifiers; an X on any of them counts as no transfer
  wire byte_xfer   = in_valid_i & ~in_stall_o;
  wire sample_xfer = out_valid_o & ~out_stall_i;
  wire reg_xfer    = cfg_valid_i & cfg_ready_o;

  // Video bytes waiting for the driver, and samples the block still owes us
  vbns_pkg::in_t  pending_bytes[$];
  vbns_pkg::out_t due_samples[$];

  // Mirror of the register file and of the block's scan state
  vbns_pkg::cfg_t regs;
  logic [6:0]     col_m   = '0;
  logic [8:0]     line_m  = '0;
  logic           last_hi = 1'b0;
  logic [7:0]     gfx_sh  = '0;
  logic [7:0]     text_sh = '0;
  logic           hi_bit  = 1'b0;

  int unsigned    scan_pos;
  int unsigned    gap_max = 8, stall_max = 8;
  int unsigned    gap_left = 0, stall_left = 0;
  logic           holding = 1'b0;
  logic           in_taken = 1'b0, out_taken = 1'b0;
  int unsigned    sample_errors = 0;
  int unsigned    quiet_cycles = 0;
  vbns_pkg::out_t want_s;

  // Work out the samples that one video byte produces and queue them in order.
  // Advance the mirrored scan state exactly as the block does.
  task automatic render_byte(input vbns_pkg::in_t b);
    logic [7:0]     lv[$];
    int unsigned    n_smp, first_blank, hc, row, cnt;
    logic           pix, line_vis, h_vis, shift, show_last, lores_odd;
    logic [3:0]     nib;
    logic [7:0]     lvl;
    vbns_pkg::out_t s;
    if (b.displaying_text) begin
      text_sh = b.video_byte;
    end else begin
      gfx_sh = b.video_byte;
      hi_bit = b.video_byte[7];
    end
    if (b.scan_index == '0) line_m = '0;
    n_smp = SPC;
    if (col_m == CPL - 1) n_smp += LONG_EXTRA;
    line_vis  = line_m < VIS_ROWS;
    h_vis     = col_m >= HIDDEN_COLS;
    shift     = !b.displaying_text && b.hires_mode && hi_bit && line_vis && h_vis &&
                regs.board_revision;
    show_last = shift && last_hi;
    if (shift) n_smp--;
    first_blank = shift ? SPC - 1 : SPC;
    hc          = col_m * SPC;
    row         = b.scan_index / CPL;
    lores_odd   = b.scan_index[0] == line_m[0];
    for (int unsigned c = 0; c < n_smp; c++) begin
      if (c == n_smp - 1) last_hi = gfx_sh[0];
      if (b.displaying_text) begin
        // text shifts at half rate
        pix = text_sh[0];
        if ((c & 1) != 0) text_sh = text_sh >> 1;
      end else if (b.hires_mode) begin
        // hi-res rotates at half rate, bit 4 refills bit 7
        pix = gfx_sh[0];
        if ((c & 1) != 0) gfx_sh = {gfx_sh[4], gfx_sh[7:1]};
      end else begin
        // lo-res: pick a nibble by row, rotate each nibble every sample
        nib    = ((row & 4) != 0) ? gfx_sh[7:4] : gfx_sh[3:0];
        pix    = lores_odd ? nib[2] : nib[0];
        gfx_sh = {gfx_sh[4], gfx_sh[7:5], gfx_sh[0], gfx_sh[3:1]};
      end
      // half-pixel delay: repeat the previous byte's last hi-res bit up front
      if (shift && c == 0) lv.push_back(show_last ? regs.lit_level : 8'h00);
      if (line_vis && h_vis) begin
        lvl = (pix && c < first_blank) ? regs.lit_level : 8'h00;
      end else if (!line_vis && line_m >= vbns_pkg::VSYNC_FIRST &&
                   line_m < vbns_pkg::VSYNC_END) begin
        lvl = regs.sync_tip;
      end else if (line_vis && hc >= regs.burst_start && hc < regs.burst_end) begin
        // burst wins over sync; text mode on the later board kills it
        if (b.text_mode && regs.board_revision) lvl = 8'h00;
        else if (((hc - regs.burst_start) & 3) == 1) lvl = -{1'b0, regs.burst_level};
        else if (((hc - regs.burst_start) & 3) == 3) lvl = {1'b0, regs.burst_level};
        else lvl = 8'h00;
      end else if (hc >= regs.hsync_begin && hc < regs.backporch_start) begin
        lvl = regs.sync_tip;
      end else begin
        lvl = 8'h00;
      end
      lv.push_back(lvl);
      hc++;
    end
    // Keep at most MAX_OUT samples; the last one kept carries the end flag
    cnt = (lv.size() < vbns_pkg::MAX_OUT) ? lv.size() : vbns_pkg::MAX_OUT;
    for (int unsigned k = 0; k < cnt; k++) begin
      s.sample_level = lv[k];
      s.last_sample  = (k == cnt - 1);
      due_samples.push_back(s);
    end
    if (col_m == CPL - 1) begin
      col_m = '0;
      if (line_m != vbns_pkg::LINE_MAX) line_m++;
    end else begin
      col_m++;
    end
  endtask

  function automatic vbns_pkg::in_t random_byte(input int unsigned t);
    vbns_pkg::in_t b;
    b.scan_index      = vbns_pkg::SCAN_W'(t);
    b.video_byte      = 8'($urandom);
    b.displaying_text = ($urandom_range(0, 3) == 0);
    b.hires_mode      = 1'($urandom_range(0, 1));
    b.text_mode       = b.displaying_text ? ($urandom_range(0, 3) != 0)
                                          : ($urandom_range(0, 3) == 0);
    return b;
  endfunction

  // Queue a run of bytes in scan order with random content. With keep_line set,
  // skip scan index zero on wrap so the line counter keeps climbing.
  task automatic push_line(input int unsigned n, input bit keep_line);
    for (int unsigned k = 0; k < n; k++) begin
      pending_bytes.push_back(random_byte(scan_pos));
      if (scan_pos == SCAN_LAST) scan_pos = keep_line ? 1 : 0;
      else scan_pos++;
    end
  endtask

  // Out-of-order scan indexes, with a fair share of line restarts and the top index
  task automatic push_noise(input int unsigned n);
    int unsigned t;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0:       t = 0;
        1:       t = SCAN_LAST;
        default: t = $urandom_range(0, SCAN_LAST);
      endcase
      pending_bytes.push_back(random_byte(t));
    end
  endtask

  // Hold until every queued byte is taken and every owed sample has come back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || holding || due_samples.size() != 0);
  endtask

  // One register transfer; leave valid high so back-to-back writes never toggle it
  task automatic set_reg(input logic [vbns_pkg::CFG_IDX_W-1:0] idx,
                         input logic [vbns_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    case (idx)
      vbns_pkg::REG_BOARD_REVISION:  regs.board_revision  = data[0];
      vbns_pkg::REG_LIT_LEVEL:       regs.lit_level       = data[7:0];
      vbns_pkg::REG_SYNC_TIP:        regs.sync_tip        = data[7:0];
      vbns_pkg::REG_BURST_LEVEL:     regs.burst_level     = data[6:0];
      vbns_pkg::REG_HSYNC_BEGIN:     regs.hsync_begin     = data;
      vbns_pkg::REG_BACKPORCH_START: regs.backporch_start = data;
      vbns_pkg::REG_BURST_START:     regs.burst_start     = data;
      vbns_pkg::REG_BURST_END:       regs.burst_end       = data;
      default: ;
    endcase
  endtask

  // Rewrite the whole register file; pad the narrow ones with junk upper bits
  task automatic load_cfg(input logic rev, input logic [7:0] white,
                          input logic [7:0] sync, input logic [6:0] burst,
                          input logic [9:0] ss, input logic [9:0] bp,
                          input logic [9:0] bs, input logic [9:0] be);
    set_reg(vbns_pkg::REG_BOARD_REVISION, {9'($urandom), rev});
    set_reg(vbns_pkg::REG_LIT_LEVEL, {2'($urandom), white});
    set_reg(vbns_pkg::REG_SYNC_TIP, {2'($urandom), sync});
    set_reg(vbns_pkg::REG_BURST_LEVEL, {3'($urandom), burst});
    set_reg(vbns_pkg::REG_HSYNC_BEGIN, ss);
    set_reg(vbns_pkg::REG_BACKPORCH_START, bp);
    set_reg(vbns_pkg::REG_BURST_START, bs);
    set_reg(vbns_pkg::REG_BURST_END, be);
    set_reg(REG_UNUSED, 10'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Byte driver: present the next pending byte after its drawn gap, hold it
  // steady while stalled, drop valid only when nothing follows right away.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) holding = 1'b0;
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          in_data_i <= pending_bytes.pop_front();
          holding   = 1'b1;
          gap_left  = $urandom_range(0, gap_max);
        end
      end
      in_valid_i <= holding;
    end
  end

  // Sample sink back-pressure: after each sample transfer, stall for a drawn count
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) stall_left = $urandom_range(0, stall_max);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Monitor: predict on every byte transfer, check every sample transfer, and
  // end the run if the channels go quiet for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= (byte_xfer === 1'b1);
      out_taken <= (sample_xfer === 1'b1);
      if (byte_xfer === 1'b1) render_byte(in_data_i);
      if (sample_xfer === 1'b1) begin
        if (due_samples.size() == 0) begin
          sample_errors++;
          $display("%0t: unexpected sample, expected none, got level %0d last %0b",
                   $time, $signed(out_data_o.sample_level), out_data_o.last_sample);
        end else begin
          want_s = due_samples.pop_front();
          if (out_data_o.sample_level !== want_s.sample_level) begin
            sample_errors++;
            $display("%0t: sample_level expected %0d, got %0d", $time,
                     $signed(want_s.sample_level), $signed(out_data_o.sample_level));
          end
          if (out_data_o.last_sample !== want_s.last_sample) begin
            sample_errors++;
            $display("%0t: last_sample expected %0b, got %0b", $time,
                     want_s.last_sample, out_data_o.last_sample);
          end
        end
      end
      if (byte_xfer === 1'b1 || sample_xfer === 1'b1 || reg_xfer === 1'b1)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    vbns_pkg::in_t b;
    // Drive every input to a known value before the first edge
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    scan_pos      = 0;
    regs.board_revision  = vbns_pkg::BOARD_REVISION_RST;
    regs.lit_level       = vbns_pkg::LIT_LEVEL_RST;
    regs.sync_tip        = vbns_pkg::SYNC_TIP_RST;
    regs.burst_level     = vbns_pkg::BURST_LEVEL_RST;
    regs.hsync_begin     = '0;
    regs.backporch_start = '0;
    regs.burst_start     = '0;
    regs.burst_end       = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // One full line on the reset register values, long last column included
    push_line(CPL, 0);
    drain();

    // Overlapping sync and burst windows at the level extremes
    load_cfg(1'b1, 8'h7F, 8'h80, 7'h7F, 10'd0, 10'd100, 10'd90, 10'd200);
    // Directed: walk the hidden columns through every mode mix and edge byte,
    // starting on a line restart and ending on the top scan index
    for (int unsigned k = 0; k < 25; k++) begin
      b.scan_index      = (k == 24) ? vbns_pkg::SCAN_W'(SCAN_LAST) : vbns_pkg::SCAN_W'(k);
      case (k % 4)
        0:       b.video_byte = 8'h00;
        1:       b.video_byte = 8'hFF;
        2:       b.video_byte = 8'h80;
        default: b.video_byte = 8'h7F;
      endcase
      b.displaying_text = k[0];
      b.hires_mode      = k[2];
      b.text_mode       = k[1];
      pending_bytes.push_back(b);
    end
    scan_pos = 25;
    push_line(4, 0);
    drain();
    // Broken scan order with no idling on either side
    gap_max   = 0;
    stall_max = 0;
    push_noise(4);
    drain();

    // Original board, opposite level extremes, sync over the whole line, no burst
    gap_max   = 8;
    stall_max = 8;
    load_cfg(1'b0, 8'h80, 8'h7F, 7'h00, 10'd0, 10'd1023, 10'd1023, 10'd0);
    scan_pos = 0;
    push_line(4, 0);
    drain();

    // Restart the line count: burst over all hidden columns, empty sync window
    load_cfg(1'b1, 8'($urandom), 8'($urandom), 7'($urandom), 10'd1023, 10'd1023,
             10'd0, 10'd1023);
    scan_pos = 0;
    push_line(3, 0);
    push_noise(3);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sample_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
